FILE: rtl/dcs_pkg.sv
// Shared types and constants for the DLE/STX/ETX character stuffer.
// No dependencies; imported by every module of the block.
package dcs_pkg;

	// Framing characters
	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_L = 8'h6C;
	localparam logic [7:0] CH_E = 8'h65;
	localparam logic [7:0] CH_S = 8'h73;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_X = 8'h78;

	// Index of the final byte in the header/trailer and in the doubled dle
	localparam logic [2:0] FRAME_SEQ_END = 3'd5;
	localparam logic [2:0] DLE_SEQ_END   = 3'd2;

	// Input beat
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_first;
		logic       frame_last;
	} item_t;

	// Result beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} res_t;

	// Classified command handed from the front to the back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       hdr;
		logic       dle;
		logic       trl;
	} cmd_t;

	// Match tracker codes
	typedef enum logic [1:0] {
		MP_NONE = 2'd0,
		MP_D    = 2'd1,
		MP_DL   = 2'd2
	} match_t;

	// Emit sequencer phases
	typedef enum logic [2:0] {
		PH_START,
		PH_HDR,
		PH_BYTE,
		PH_DLE,
		PH_TRL
	} phase_t;

	// Header "dlestx"
	function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = CH_D;
			3'd1: b = CH_L;
			3'd2: b = CH_E;
			3'd3: b = CH_S;
			3'd4: b = CH_T;
			3'd5: b = CH_X;
			default: b = CH_X;
		endcase
		return b;
	endfunction

	// Trailer "dleetx"
	function automatic logic [7:0] trl_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = CH_D;
			3'd1: b = CH_L;
			3'd2: b = CH_E;
			3'd3: b = CH_E;
			3'd4: b = CH_T;
			3'd5: b = CH_X;
			default: b = CH_X;
		endcase
		return b;
	endfunction

	// Doubled "dle"
	function automatic logic [7:0] dle_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = CH_D;
			3'd1: b = CH_L;
			default: b = CH_E;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/dcs_front.sv
// Front end: takes input beats, runs the dle match tracker, builds commands.
// Depends on dcs_pkg.
module dcs_front import dcs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid,
	input  logic  q_full,
	input  item_t item,
	output logic  stall,
	output logic  push,
	output cmd_t  cmd
);

	match_t match_q;
	match_t p_cur;
	match_t p_next;
	logic   done;

	assign stall = q_full;
	assign push  = valid && !q_full;

	// Tracker update; a new frame drops any partial match
	always_comb begin
		p_cur = item.frame_first ? MP_NONE : match_q;
		done  = 1'b0;
		if (p_cur == MP_DL && item.data_byte == CH_E) begin
			done   = 1'b1;
			p_next = MP_NONE;
		end else if (p_cur == MP_D && item.data_byte == CH_L) begin
			p_next = MP_DL;
		end else if (item.data_byte == CH_D) begin
			p_next = MP_D;
		end else begin
			p_next = MP_NONE;
		end
		if (item.frame_last) begin
			p_next = MP_NONE;
		end
	end

	always_comb begin
		cmd.data_byte = item.data_byte;
		cmd.hdr       = item.frame_first;
		cmd.dle       = done;
		cmd.trl       = item.frame_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= MP_NONE;
		end else if (push) begin
			match_q <= p_next;
		end
	end

endmodule

FILE: rtl/dcs_queue.sv
// Short command queue between the front and the back end.
// Depends on dcs_pkg for the command type.
module dcs_queue import dcs_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  cmd_t                       wr_cmd,
	input  logic                       pop,
	output logic                       full,
	output logic                       not_empty,
	output cmd_t                       head,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	cmd_t          slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign head      = slot_q[rd_ptr_q];
	assign count     = cnt_q;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

FILE: rtl/dcs_back.sv
// Back end: walks one command through header, byte, doubled dle and trailer,
// one output byte per cycle into the output register while not stalled. Depends on dcs_pkg.
module dcs_back import dcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  cmd_t head,
	output logic pop,
	output logic valid,
	input  logic stall,
	output res_t res
);

	phase_t     phase_q;
	phase_t     phase_eff;
	phase_t     phase_next;
	logic [2:0] idx_q;
	logic [2:0] idx_next;
	logic       seg_end;
	logic       cmd_end;
	logic       adv;
	logic [7:0] byte_cur;
	logic       out_valid_q;
	res_t       out_q;

	assign adv = head_valid && (!out_valid_q || !stall);

	// A fresh command opens with the header only when it starts a frame
	always_comb begin
		phase_eff = phase_q;
		if (phase_q == PH_START) begin
			phase_eff = head.hdr ? PH_HDR : PH_BYTE;
		end
	end

	// Outputs of the sequencer: current byte and segment ends
	always_comb begin
		byte_cur = head.data_byte;
		seg_end  = 1'b1;
		cmd_end  = 1'b0;
		case (phase_eff)
			PH_HDR: begin
				byte_cur = hdr_byte(idx_q);
				seg_end  = (idx_q == FRAME_SEQ_END);
			end
			PH_BYTE: begin
				byte_cur = head.data_byte;
				seg_end  = 1'b1;
				cmd_end  = !head.dle && !head.trl;
			end
			PH_DLE: begin
				byte_cur = dle_byte(idx_q);
				seg_end  = (idx_q == DLE_SEQ_END);
				cmd_end  = seg_end && !head.trl;
			end
			PH_TRL: begin
				byte_cur = trl_byte(idx_q);
				seg_end  = (idx_q == FRAME_SEQ_END);
				cmd_end  = seg_end;
			end
			default: begin
				byte_cur = head.data_byte;
				seg_end  = 1'b1;
				cmd_end  = 1'b0;
			end
		endcase
	end

	// Next state of the sequencer
	always_comb begin
		phase_next = phase_eff;
		idx_next   = idx_q + 3'd1;
		if (seg_end) begin
			idx_next = 3'd0;
			case (phase_eff)
				PH_HDR:  phase_next = PH_BYTE;
				PH_BYTE: phase_next = head.dle ? PH_DLE : (head.trl ? PH_TRL : PH_START);
				PH_DLE:  phase_next = head.trl ? PH_TRL : PH_START;
				PH_TRL:  phase_next = PH_START;
				default: phase_next = PH_START;
			endcase
		end
	end

	assign pop = adv && cmd_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			idx_q   <= 3'd0;
		end else if (adv) begin
			phase_q <= phase_next;
			idx_q   <= idx_next;
		end
	end

	// Output register; refills while the receiver takes the held beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !stall) begin
			out_valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.out_byte <= byte_cur;
			out_q.run_last <= cmd_end;
		end
	end

	assign valid = out_valid_q;
	assign res   = out_q;

endmodule

FILE: rtl/dle_character_stuffer_unit.sv
// DLE/STX/ETX character stuffer, sender side.
// Input beats carry one payload byte with first/last frame marks; result
// beats carry one stuffed byte each, run_last set on the final byte that an
// input beat causes.
// A first byte is preceded by the header "dlestx", a byte that completes a
// non-overlapping "dle" is followed by another "dle", and a last byte is
// followed by the trailer "dleetx". One input beat yields 1 to 13 bytes.
// With the queue empty and no stall, the first byte of a beat passes
// through the command queue and then the output register.
// Throughput: the output register moves one byte per cycle while the
// receiver does not stall. The command queue (QDEPTH entries) lets input
// beats be taken while the back end is busy.
// When the receiver stalls, the held result beat stays put; input is
// stalled only once the queue is full.
// Reset clears the match tracker, the queue and the output register; no
// beat is lost or invented across stalls.
// Depends on dcs_pkg, dcs_front, dcs_queue, dcs_back.
module dle_character_stuffer_unit import dcs_pkg::*; #(
	parameter int QDEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  res_valid,
	input  logic  res_stall,
	output res_t  res
);

	localparam int CW = $clog2(QDEPTH + 1);

	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_not_empty;
	cmd_t          wr_cmd;
	cmd_t          head;
	logic [CW-1:0] q_count;

	dcs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (item_valid),
		.q_full (q_full),
		.item   (item),
		.stall  (item_stall),
		.push   (push),
		.cmd    (wr_cmd)
	);

	dcs_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (wr_cmd),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head),
		.count     (q_count)
	);

	dcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_not_empty),
		.head       (head),
		.pop        (pop),
		.valid      (res_valid),
		.stall      (res_stall),
		.res        (res)
	);

`ifndef SYNTHESIS
	// Fill count never exceeds the queue depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CW'(QDEPTH))
		else $error("queue count above depth");

	// A push without a pop grows the queue by exactly one
	a_count_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (q_count == $past(q_count) + CW'(1)))
		else $error("queue count did not follow push");

	// The back end only pops a command it holds
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_not_empty)
		else $error("pop from empty queue");

	// A stalled result beat holds its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("stalled result beat changed");
`endif

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for dle_character_stuffer_unit: directed and random frames,
// with stuffed output predicted per input beat and compared byte by byte.
// Depends on dcs_pkg and the RTL of the block.
module testbench;
	import dcs_pkg::*;

	typedef struct {
		item_t beat;
		bit    wait_idle;  // hold this beat back until every output byte has arrived
	} queued_beat_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_stall;
	item_t item = '0;
	logic  res_valid;
	logic  res_stall = 1'b0;
	res_t  res;

	queued_beat_t frame_beats[$];
	res_t         stuffed_bytes_due[$];
	match_t       dle_progress = MP_NONE;

	int beats_in = 0;
	int bytes_out = 0;
	int mismatches = 0;
	bit drained = 1'b1;
	int beats_offered = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	dle_character_stuffer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Expected bytes for one input beat: header, byte, doubled dle, trailer
	function automatic void stuff_beat(input item_t b);
		logic [7:0] stx_header[6] = '{CH_D, CH_L, CH_E, CH_S, CH_T, CH_X};
		logic [7:0] etx_trailer[6] = '{CH_D, CH_L, CH_E, CH_E, CH_T, CH_X};
		logic [7:0] seq[$];
		match_t     p;
		bit         doubled;
		res_t       r;
		p = dle_progress;
		doubled = 1'b0;
		if (b.frame_first) begin
			p = MP_NONE;
			foreach (stx_header[k]) seq.push_back(stx_header[k]);
		end
		seq.push_back(b.data_byte);
		// tracker: a 'd' that breaks a partial match starts a new one
		if (p == MP_DL && b.data_byte == CH_E) begin
			doubled = 1'b1;
			p = MP_NONE;
		end else if (p == MP_D && b.data_byte == CH_L) begin
			p = MP_DL;
		end else if (b.data_byte == CH_D) begin
			p = MP_D;
		end else begin
			p = MP_NONE;
		end
		if (doubled) begin
			seq.push_back(CH_D);
			seq.push_back(CH_L);
			seq.push_back(CH_E);
		end
		if (b.frame_last) begin
			foreach (etx_trailer[k]) seq.push_back(etx_trailer[k]);
			p = MP_NONE;
		end
		dle_progress = p;
		foreach (seq[k]) begin
			r.out_byte = seq[k];
			r.run_last = (k == seq.size() - 1);
			stuffed_bytes_due.push_back(r);
		end
	endfunction

	// Monitor: check output beats first, then predict from the accepted input beat
	always @(posedge clk) begin : monitor
		res_t due;
		int   bad;
		bad = 0;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				bytes_out <= bytes_out + 1;
				if (stuffed_bytes_due.size() == 0) begin
					$display("%0t: unexpected output byte %02h run_last %b", $time,
						res.out_byte, res.run_last);
					bad++;
				end else begin
					due = stuffed_bytes_due.pop_front();
					if (res.out_byte !== due.out_byte) begin
						$display("%0t: out_byte expected %02h got %02h", $time,
							due.out_byte, res.out_byte);
						bad++;
					end
					if (res.run_last !== due.run_last) begin
						$display("%0t: run_last expected %b got %b", $time,
							due.run_last, res.run_last);
						bad++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				beats_in <= beats_in + 1;
				stuff_beat(item);
			end
			mismatches <= mismatches + bad;
			drained <= (stuffed_bytes_due.size() == 0);
		end
	end

	// Driver: offer queued beats, hold while stalled, idle at random
	always @(posedge clk) begin : driver
		queued_beat_t nxt;
		bit           go;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!(item_valid && item_stall)) begin
			go = frame_beats.size() > 0;
			if (go && frame_beats[0].wait_idle)
				go = drained && !item_valid;
			// no idling across a middle stretch of the run
			if (go && !(beats_offered >= 150 && beats_offered < 220))
				go = $urandom_range(0, 99) >= 34;
			if (go) begin
				nxt = frame_beats.pop_front();
				item <= nxt.beat;
				item_valid <= 1'b1;
				beats_offered++;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, one long hold-off, one stretch with none
	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (!hold_done && beats_in >= 60) begin
				hold_left = 200;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (beats_in >= 150 && beats_in < 220) begin
				res_stall <= 1'b0;
			end else begin
				res_stall <= ($urandom_range(0, 99) < 34);
			end
		end
	end

	task automatic queue_beat(input logic [7:0] b, input bit f, input bit l,
			input bit hold = 1'b0);
		queued_beat_t q;
		q.beat.data_byte = b;
		q.beat.frame_first = f;
		q.beat.frame_last = l;
		q.wait_idle = hold;
		frame_beats.push_back(q);
	endtask

	// Payload byte biased toward the dle characters
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) return CH_D;
		if (r < 5) return CH_L;
		if (r < 7) return CH_E;
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin : stimulus
		int n;
		int len;
		int kind;
		bit f;
		bit l;
		// single-byte frames at both byte extremes
		queue_beat(8'h00, 1'b1, 1'b1);
		queue_beat(8'hFF, 1'b1, 1'b1);
		// plain dle doubled
		queue_beat(CH_D, 1'b1, 1'b0);
		queue_beat(CH_L, 1'b0, 1'b0);
		queue_beat(CH_E, 1'b0, 1'b0);
		// restart on a second d
		queue_beat(CH_D, 1'b0, 1'b0);
		queue_beat(CH_D, 1'b0, 1'b0);
		queue_beat(CH_L, 1'b0, 1'b0);
		queue_beat(CH_E, 1'b0, 1'b0);
		// d l d l e
		queue_beat(CH_D, 1'b0, 1'b0);
		queue_beat(CH_L, 1'b0, 1'b0);
		queue_beat(CH_D, 1'b0, 1'b0);
		queue_beat(CH_L, 1'b0, 1'b0);
		queue_beat(CH_E, 1'b0, 1'b0);
		// right after a match: no overlap
		queue_beat(CH_L, 1'b0, 1'b0);
		queue_beat(CH_E, 1'b0, 1'b0);
		queue_beat(CH_E, 1'b0, 1'b1);
		// bytes with no first marker, match completing on the last byte
		queue_beat(CH_D, 1'b0, 1'b0);
		queue_beat(CH_L, 1'b0, 1'b0);
		queue_beat(CH_E, 1'b0, 1'b1);
		// new frame cuts a partial match
		queue_beat(CH_D, 1'b1, 1'b0);
		queue_beat(CH_L, 1'b0, 1'b0);
		queue_beat(CH_E, 1'b1, 1'b1);

		// random frames, mostly well formed
		n = 0;
		while (n < 330) begin
			kind = $urandom_range(0, 99);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				f = (i == 0);
				l = (i == len - 1);
				if (kind < 10) begin
					f = $urandom_range(0, 1);
					l = $urandom_range(0, 1);
				end else if (kind < 15) begin
					l = 1'b0;
				end else if (kind < 20) begin
					f = 1'b0;
				end
				queue_beat(pick_char(), f, l, (n == 0) || (n == 250));
				n++;
			end
		end

		wait (arst_n === 1'b1);
		do @(negedge clk);
		while (frame_beats.size() != 0 || item_valid || !drained);
		repeat (30) @(negedge clk);
		if (stuffed_bytes_due.size() != 0) begin
			$display("%0t: %0d output bytes never arrived, next expected %02h", $time,
				stuffed_bytes_due.size(), stuffed_bytes_due[0].out_byte);
			mismatches++;
		end
		$display("Ran %0d input beats into %0d stuffed bytes, %0d byte errors.",
			beats_in, bytes_out, mismatches);
		$display("Covered headers, trailers, doubled dle, broken frames and long output stalls.");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: dle_character_stuffer_unit.f
rtl/dcs_pkg.sv
rtl/dcs_front.sv
rtl/dcs_queue.sv
rtl/dcs_back.sv
rtl/dle_character_stuffer_unit.sv
verif/testbench.sv
